FILE: rtl/alu_pkg.sv
// ----------------------------------------------------------------------------
// ALU package
// Shared widths, pipeline depth and function codes for the pipelined ALU.
// ----------------------------------------------------------------------------
package alu_pkg;

  // Operand and result width.
  localparam int DATA_WIDTH = 32;

  // Function code width and codes.
  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_AND = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_OR  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_XOR = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd7;

  // One quotient bit is resolved per divider stage.
  localparam int DIV_STAGES = DATA_WIDTH;

  // Cycles from the accepting edge to the edge that ends the strobe cycle.
  localparam int LATENCY = DIV_STAGES + 1;

endpackage

FILE: rtl/alu_logic_arith_mul_div.sv
// ----------------------------------------------------------------------------
// alu_logic_arith_mul_div
// A transfer accepted at one clock edge passes through the input stage and
// one restoring-divider stage per quotient bit; its result then appears at
// the output with done high.
// Throughput: one transfer per cycle; busy is never raised, and the receiver
// cannot stall the pipeline.
// Reset (rst, synchronous) clears all valid bits; items in flight are lost.
// ----------------------------------------------------------------------------
// Pipelined 32-bit unsigned ALU: logic ops, add, sub, mul and divide.
// ----------------------------------------------------------------------------
module alu_logic_arith_mul_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [alu_pkg::FUNC_W-1:0]      func,
  input  logic [alu_pkg::DATA_WIDTH-1:0]  operand_a,
  input  logic [alu_pkg::DATA_WIDTH-1:0]  operand_b,
  output logic                            done,
  output logic [alu_pkg::DATA_WIDTH-1:0]  result,
  output logic                            div_by_zero
);
  import alu_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam int N = DIV_STAGES;

  // Per-stage pipeline registers. Stage 0 is the input stage.
  logic         vld [0:N];
  logic         dz  [0:N];
  logic [W-1:0] quo [0:N];
  logic         isd [0:N-1];
  logic [W-1:0] rem [0:N-1];
  logic [W-1:0] dvs [0:N-1];

  logic         accept;
  logic [W-1:0] mul_lo;
  logic [W-1:0] alu_val;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Low half of the product; registered in the input stage.
  assign mul_lo = operand_a * operand_b;

  // Non-divide results are computed up front and ride the pipeline.
  always_comb begin
    case (func)
      FUNC_AND: alu_val = operand_a & operand_b;
      FUNC_OR:  alu_val = operand_a | operand_b;
      FUNC_XOR: alu_val = operand_a ^ operand_b;
      FUNC_NOT: alu_val = ~operand_a;
      FUNC_ADD: alu_val = operand_a + operand_b;
      FUNC_SUB: alu_val = operand_a - operand_b;
      FUNC_MUL: alu_val = mul_lo;
      FUNC_DIV: alu_val = operand_a;
      default:  alu_val = '0;
    endcase
  end

  // Input stage: capture the transfer and seed the divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    isd[0] <= (func == FUNC_DIV);
    dz[0]  <= (func == FUNC_DIV) && (operand_b == '0);
    quo[0] <= alu_val;
    rem[0] <= '0;
    dvs[0] <= operand_b;
  end

  // Restoring divider: each stage shifts in one dividend bit and resolves
  // one quotient bit. A zero divisor yields all ones, as required.
  for (genvar k = 1; k <= N; k++) begin : g_div_stage
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem[k-1], quo[k-1][W-1]};
    assign ge    = (trial >= {1'b0, dvs[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      dz[k] <= dz[k-1];
      if (isd[k-1]) begin
        quo[k] <= {quo[k-1][W-2:0], ge};
      end else begin
        quo[k] <= quo[k-1];
      end
    end

    // The last stage needs no remainder or divisor.
    if (k < N) begin : g_carry
      logic [W:0] diff;

      assign diff = trial - {1'b0, dvs[k-1]};

      always_ff @(posedge clk) begin
        isd[k] <= isd[k-1];
        dvs[k] <= dvs[k-1];
        rem[k] <= ge ? diff[W-1:0] : trial[W-1:0];
      end
    end
  end

  // The last stage register is the output register.
  assign done        = vld[N];
  assign result      = quo[N];
  assign div_by_zero = dz[N] && vld[N];

  // Every accepted transfer is answered with a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LATENCY) done)
    else $error("result strobe missing after accepted transfer");

  // No strobe appears without a matching accepted transfer.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transfer");

  // A divide by zero returns all ones.
  a_dz_ones: assert property (@(posedge clk) disable iff (rst)
    div_by_zero |-> (result == '1))
    else $error("divide by zero result is not all ones");

  // A divide with a zero divisor raises the flag at the output.
  a_dz_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_DIV && operand_b == '0) |-> ##(LATENCY) div_by_zero)
    else $error("divide by zero flag not raised");

endmodule

FILE: dv/alu_result_checker.sv
// ----------------------------------------------------------------------------
// ALU result checker
// Watches the command and result channels of the ALU. It works out the
// expected result of every accepted transfer and compares each strobed
// result, in order, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module alu_result_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [alu_pkg::FUNC_W-1:0]     func,
  input  logic [alu_pkg::DATA_WIDTH-1:0] operand_a,
  input  logic [alu_pkg::DATA_WIDTH-1:0] operand_b,
  input  logic                           done,
  input  logic [alu_pkg::DATA_WIDTH-1:0] result,
  input  logic                           div_by_zero,
  output int unsigned                    failures,
  output int unsigned                    outstanding,
  output int unsigned                    checked,
  output int unsigned                    zero_divides
);
  import alu_pkg::*;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  zero_div;
  } alu_answer_t;

  // Expected answers of accepted transfers, oldest first.
  alu_answer_t answer_queue[$];

  int unsigned fail_cnt   = 0;
  int unsigned check_cnt  = 0;
  int unsigned zdiv_cnt   = 0;

  initial begin
    failures     = 0;
    outstanding  = 0;
    checked      = 0;
    zero_divides = 0;
  end

  // All arithmetic wraps at the operand width; a zero divisor gives all ones
  // and raises the flag.
  function automatic alu_answer_t predict_alu(logic [FUNC_W-1:0] op,
                                              logic [DATA_WIDTH-1:0] a,
                                              logic [DATA_WIDTH-1:0] b);
    alu_answer_t ans;
    ans.zero_div = 1'b0;
    case (op)
      FUNC_AND: ans.value = a & b;
      FUNC_OR:  ans.value = a | b;
      FUNC_XOR: ans.value = a ^ b;
      FUNC_NOT: ans.value = ~a;
      FUNC_ADD: ans.value = a + b;
      FUNC_SUB: ans.value = a - b;
      FUNC_MUL: ans.value = a * b;
      default: begin
        if (b == '0) begin
          ans.value    = '1;
          ans.zero_div = 1'b1;
        end else begin
          ans.value = a / b;
        end
      end
    endcase
    return ans;
  endfunction

  // Results are compared before the new transfer is queued; the pipeline
  // never returns a result at the edge that accepts its command.
  always @(posedge clk) begin
    alu_answer_t want;
    if (rst) begin
      answer_queue.delete();
    end else begin
      if (done) begin
        if (answer_queue.size() == 0) begin
          $display("%0t: result %h flag %b arrived with no transfer outstanding",
                   $time, result, div_by_zero);
          fail_cnt++;
        end else begin
          want = answer_queue.pop_front();
          check_cnt++;
          if (want.zero_div) zdiv_cnt++;
          if (result !== want.value) begin
            $display("%0t: result mismatch, expected %h, actual %h",
                     $time, want.value, result);
            fail_cnt++;
          end
          if (div_by_zero !== want.zero_div) begin
            $display("%0t: div_by_zero mismatch, expected %b, actual %b",
                     $time, want.zero_div, div_by_zero);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        answer_queue.push_back(predict_alu(func, operand_a, operand_b));
      end
    end
    failures     <= fail_cnt;
    outstanding  <= answer_queue.size();
    checked      <= check_cnt;
    zero_divides <= zdiv_cnt;
  end

endmodule

FILE: dv/alu_logic_arith_mul_div_tb.sv
// ----------------------------------------------------------------------------
// ALU testbench
// Drives directed corner cases of every function code, then about 1300
// random commands with random idle bursts, and lets the checker compare
// every result against its own prediction.
// ----------------------------------------------------------------------------
module alu_logic_arith_mul_div_tb;
  import alu_pkg::*;

  localparam int NUM_ITEMS   = 1300;
  localparam int QUIET_TAIL  = 150;
  localparam int DRAIN_AT    = 600;
  localparam int CYCLE_LIMIT = 100000;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  start       = 1'b0;
  logic [FUNC_W-1:0]     func        = FUNC_AND;
  logic [DATA_WIDTH-1:0] operand_a   = '0;
  logic [DATA_WIDTH-1:0] operand_b   = '0;
  logic                  busy;
  logic                  done;
  logic [DATA_WIDTH-1:0] result;
  logic                  div_by_zero;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned zero_divides;
  int unsigned cycle_count = 0;
  int unsigned sent        = 0;

  // Clock with a 12 unit period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  alu_logic_arith_mul_div dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .done        (done),
    .result      (result),
    .div_by_zero (div_by_zero)
  );

  alu_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .done         (done),
    .result       (result),
    .div_by_zero  (div_by_zero),
    .failures     (failures),
    .outstanding  (outstanding),
    .checked      (checked),
    .zero_divides (zero_divides)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Presents one command and holds it until the transfer takes place.
  task automatic send(logic [FUNC_W-1:0] f, logic [DATA_WIDTH-1:0] a,
                      logic [DATA_WIDTH-1:0] b);
    start     <= 1'b1;
    func      <= f;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drops start for a random burst of cycles.
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  // Drops start and waits until every outstanding result has been checked.
  // The first edge lets the checker count the last transfer.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Operands biased toward zero, all ones, single bits and small values.
  function automatic logic [DATA_WIDTH-1:0] pick_operand();
    logic [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = DATA_WIDTH'($urandom_range(0, 255));
      3:       v = DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
      4:       v = ~(DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1));
      5:       v = DATA_WIDTH'($urandom_range(0, 65535));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  initial begin
    logic [FUNC_W-1:0]     f;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    bit                    quiet_stretch;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners of every function, including the zero divisor.
    send(FUNC_AND, '1, '1);
    send(FUNC_AND, 32'hAAAA_5555, 32'h0F0F_F0F0);
    send(FUNC_OR,  '0, '0);
    send(FUNC_OR,  32'h8000_0000, 32'h0000_0001);
    send(FUNC_XOR, '1, 32'h1234_5678);
    send(FUNC_XOR, '1, '1);
    send(FUNC_NOT, '0, '1);
    send(FUNC_NOT, 32'hDEAD_BEEF, 32'h5A5A_5A5A);
    send(FUNC_ADD, '1, 32'd1);
    send(FUNC_ADD, '1, '1);
    send(FUNC_ADD, '0, '0);
    send(FUNC_SUB, '0, 32'd1);
    send(FUNC_SUB, 32'd5, 32'd5);
    send(FUNC_SUB, '1, '0);
    send(FUNC_MUL, '1, '1);
    send(FUNC_MUL, 32'h0001_0000, 32'h0001_0000);
    send(FUNC_MUL, 32'hFFFF_FFFF, 32'd0);
    send(FUNC_DIV, 32'd100, 32'd0);
    send(FUNC_DIV, '0, '0);
    send(FUNC_DIV, '1, 32'd1);
    send(FUNC_DIV, '1, '1);
    send(FUNC_DIV, 32'd7, 32'd9);
    send(FUNC_DIV, '1, 32'h8000_0000);
    send(FUNC_DIV, 32'd1000, 32'd7);

    // Random commands; the last stretch runs back to back.
    quiet_stretch = 1'b0;
    while (sent < NUM_ITEMS) begin
      if (sent % 40 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
      if (sent == DRAIN_AT) drain();
      if (!quiet_stretch && sent < NUM_ITEMS - QUIET_TAIL &&
          $urandom_range(0, 3) == 0) begin
        idle_burst();
      end
      f = FUNC_W'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      if (f == FUNC_DIV && $urandom_range(0, 7) == 0) b = '0;
      send(f, a, b);
    end

    // Let the pipeline empty, then watch for stray results.
    drain();
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d commands over all eight functions; checked %0d results,",
             sent, checked);
    $display("%0d of them divides by zero.", zero_divides);
    if (failures == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/alu_pkg.sv
rtl/alu_logic_arith_mul_div.sv
dv/alu_result_checker.sv
dv/alu_logic_arith_mul_div_tb.sv
